>>> rtl/assert_macros.svh
// Assertion helpers for the interrupt combiner.
// Expects clk_i and rst_ni in the scope of the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, disabled while in reset.
`define SIC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed in %m");

// Antecedent this cycle, consequent on the next clock.
`define SIC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

>>> rtl/sic_pkg.sv
// Shared types, constants and helpers for the interrupt combiner.
// No dependencies.
package sic_pkg;

  localparam int NUM_IRQS       = 512;
  localparam int IRQS_PER_LINE  = 64;
  localparam int RESERVED_IRQS  = 32;
  localparam int WORDS          = NUM_IRQS / 32;
  localparam int WORDS_PER_LINE = IRQS_PER_LINE / 32;
  localparam int NUM_LINES      = NUM_IRQS / IRQS_PER_LINE;
  localparam int WIDX_W         = $clog2(WORDS);

  localparam logic [9:0] OFS_CTL   = 10'h000;
  localparam logic [9:0] OFS_FIRST = 10'h004;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RAW   = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  byte_offset;
    logic [31:0] write_value;
    logic [3:0]  input_word_index;
    logic [31:0] input_levels;
  } sic_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [7:0]  line_outputs;
    logic        bad_address;
  } sic_out_t;

  // register decode of one bus offset
  typedef struct packed {
    logic              is_ctl;
    logic              is_mask;
    logic              is_force;
    logic              is_status;
    logic              is_bad;
    logic [WIDX_W-1:0] widx;
  } sic_dec_t;

  // inputs below RESERVED_IRQS are tied low in raw word w
  function automatic logic [31:0] tied_low_bits(logic [WIDX_W-1:0] w);
    logic [31:0] bits;
    bits = '0;
    for (int i = 0; i < 32; i++) begin
      bits[i] = ((32 * int'(w) + i) < RESERVED_IRQS);
    end
    return bits;
  endfunction

endpackage

>>> rtl/sic_decode.sv
// Address decoder: byte offset to register region and word index.
// Depends on sic_pkg.
module sic_decode
  import sic_pkg::*;
(
  input  logic [9:0] byte_offset_i,
  output sic_dec_t   dec_o
);

  logic [9:0] ofs_al;
  logic [7:0] k;
  logic [7:0] region;

  always_comb begin
    ofs_al = {byte_offset_i[9:2], 2'b00};
    k      = 8'((ofs_al - OFS_FIRST) >> 2);
    region = 8'(k / WORDS);

    dec_o.is_ctl    = (ofs_al == OFS_CTL);
    dec_o.is_mask   = !dec_o.is_ctl && (region == 8'd0);
    dec_o.is_force  = !dec_o.is_ctl && (region == 8'd1);
    dec_o.is_status = !dec_o.is_ctl && (region == 8'd2);
    dec_o.is_bad    = !dec_o.is_ctl && (region > 8'd2);
    // regions are laid out in reverse word order
    dec_o.widx      = WIDX_W'(WORDS - 1 - int'(k % WORDS));
  end

endmodule

>>> rtl/sic_regs.sv
// Register file and combining logic: channel enable, mask, force, raw words.
// Depends on sic_pkg; decode comes from sic_decode.
module sic_regs
  import sic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  sic_in_t  item_i,
  input  sic_dec_t dec_i,
  output sic_out_t res_o
);

  logic        chan_en_q, chan_en_d;
  logic [31:0] mask_q  [WORDS];
  logic [31:0] mask_d  [WORDS];
  logic [31:0] force_q [WORDS];
  logic [31:0] force_d [WORDS];
  logic [31:0] raw_q   [WORDS];
  logic [31:0] raw_d   [WORDS];
  logic [31:0] stat_d  [WORDS];
  logic [31:0] rdata;
  logic [7:0]  lines;
  logic        any;
  logic        is_bus;

  // next state
  always_comb begin
    chan_en_d = chan_en_q;
    mask_d    = mask_q;
    force_d   = force_q;
    raw_d     = raw_q;
    if (step_i) begin
      case (item_i.req_type)
        REQ_WRITE: begin
          if (dec_i.is_ctl)   chan_en_d             = item_i.write_value[0];
          if (dec_i.is_mask)  mask_d[dec_i.widx]    = item_i.write_value;
          if (dec_i.is_force) force_d[dec_i.widx]   = item_i.write_value;
        end
        REQ_RAW: begin
          if (int'(item_i.input_word_index) < WORDS) begin
            raw_d[WIDX_W'(item_i.input_word_index)] =
              item_i.input_levels & ~tied_low_bits(WIDX_W'(item_i.input_word_index));
          end
        end
        default: ;
      endcase
    end
  end

  // read data from pre-step state
  always_comb begin
    rdata  = '0;
    is_bus = (item_i.req_type == REQ_READ) || (item_i.req_type == REQ_WRITE);
    if (item_i.req_type == REQ_READ) begin
      if (dec_i.is_ctl)    rdata = {31'b0, chan_en_q};
      if (dec_i.is_mask)   rdata = mask_q[dec_i.widx];
      if (dec_i.is_force)  rdata = force_q[dec_i.widx];
      if (dec_i.is_status) rdata = (raw_q[dec_i.widx] | force_q[dec_i.widx])
                                   & mask_q[dec_i.widx];
    end
  end

  // line levels after the step
  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      stat_d[w] = (raw_d[w] | force_d[w]) & mask_d[w];
    end
    lines = '0;
    for (int n = 0; n < 8; n++) begin
      any = 1'b0;
      if (n < NUM_LINES) begin
        for (int j = 0; j < WORDS_PER_LINE; j++) begin
          if (n * WORDS_PER_LINE + j < WORDS) begin
            any = any | (|stat_d[n * WORDS_PER_LINE + j]);
          end
        end
      end
      lines[n] = chan_en_d & any;
    end
  end

  assign res_o.read_value   = rdata;
  assign res_o.line_outputs = lines;
  assign res_o.bad_address  = is_bus & dec_i.is_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_en_q <= 1'b0;
      for (int w = 0; w < WORDS; w++) begin
        mask_q[w]  <= '0;
        force_q[w] <= '0;
        raw_q[w]   <= '0;
      end
    end else begin
      chan_en_q <= chan_en_d;
      mask_q    <= mask_d;
      force_q   <= force_d;
      raw_q     <= raw_d;
    end
  end

endmodule

>>> rtl/shared_interrupt_steer_combiner.sv
// Masked interrupt combiner, 512 shared inputs onto 8 output lines.
// Path: an accepted word goes through the input register, then the result register that drives out_word_o.
// Throughput: one word per cycle unless out_stall_i holds the result; input register and result register let a new
// word in while a finished result waits on out_stall_i.
// Reset: rst_ni async low; enable, mask, force and raw words clear to zero.
// Depends on sic_pkg, sic_decode, sic_regs and assert_macros.svh.
`include "assert_macros.svh"
module shared_interrupt_steer_combiner
  import sic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sic_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sic_out_t out_word_o
);

  // input register
  logic     s1_valid_q;
  sic_in_t  s1_item_q;
  // result register
  logic     out_valid_q;
  sic_out_t out_item_q;

  logic     advance;
  logic     in_take;
  sic_dec_t dec;
  sic_out_t res;

  // s1 moves to the result register whenever that register is free or draining.
  // The state update happens on this same edge, so words are processed in order.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  sic_decode u_decode (
    .byte_offset_i (s1_item_q.byte_offset),
    .dec_o         (dec)
  );

  sic_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item_q),
    .dec_i  (dec),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_item_q;

  // a processed word always lands in the result register
  `SIC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_o)
  // unmapped accesses never return data
  `SIC_ASSERT(a_bad_reads_zero, advance && res.bad_address |-> res.read_value == '0)
  // input only stalls when both stages are occupied
  `SIC_ASSERT(a_stall_when_full, in_stall_o |-> s1_valid_q && out_valid_q)

endmodule
